>>> sv/flef_pkg.sv
// Types and constants shared by the fixed-length event frame parser.
package flef_pkg;

    // Frame layout: header, length byte, payload, two trailer bytes.
    localparam int unsigned FRAME_LEN = 13;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned CFG_W     = 8;

    localparam logic [7:0] LENGTH_CODE = 8'(FRAME_LEN);

    // Configuration register indexes.
    localparam logic CFG_HEADER_VALUE = 1'b0;
    localparam logic CFG_EVENT_ENABLE = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT      = 3'd0,
        PH_LENGTH    = 3'd1,
        PH_PAYLOAD   = 3'd2,
        PH_TRAILER_A = 3'd3,
        PH_TRAILER_B = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0]         command;
        logic signed [31:0] param_one;
        logic signed [31:0] param_two;
        logic signed [31:0] param_three;
    } event_t;

endpackage

>>> sv/flef_if.sv
// Handshake interfaces for the received byte channel and the event channel.
interface flef_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface flef_event_if;
    logic               valid;
    logic               ready;
    logic [7:0]         command;
    logic signed [31:0] param_one;
    logic signed [31:0] param_two;
    logic signed [31:0] param_three;

    modport source (output valid, output command, output param_one, output param_two,
                    output param_three, input ready);
    modport sink   (input valid, input command, input param_one, input param_two,
                    input param_three, output ready);
endinterface

>>> sv/flef_in_stage.sv
// Input register holding one received byte until the parser takes it.
module flef_in_stage
    import flef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       in_ready,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // The stage can take a byte when empty or when its byte moves on this cycle.
    assign in_ready   = !valid_reg || advance;
    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

>>> sv/flef_parser.sv
// Frame state machine with the payload shift line and event assembly.
module flef_parser
    import flef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] rx_byte,
    input  logic [7:0] header_value,
    input  logic       event_enable,
    output logic       ev_valid,
    output event_t     ev
);

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         pl_reg [FRAME_LEN];
    logic               shift_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_en   = 1'b0;
        ev_valid   = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == header_value)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                count_next = '0;
                if (rx_byte == LENGTH_CODE)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_PAYLOAD:
            begin
                shift_en   = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == COUNT_W'(FRAME_LEN - 1))
                begin
                    phase_next = PH_TRAILER_A;
                end
            end
            PH_TRAILER_A:
            begin
                phase_next = PH_TRAILER_B;
            end
            PH_TRAILER_B:
            begin
                ev_valid   = advance && event_enable;
                phase_next = PH_HUNT;
                count_next = '0;
            end
            default:
            begin
                phase_next = PH_HUNT;
                count_next = '0;
            end
        endcase
    end

    // Payload bytes enter at the top and drift down, so after a full payload
    // the first byte sits at the bottom entry.
    always_ff @(posedge clk)
    begin
        if (advance && shift_en)
        begin
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                pl_reg[i] <= pl_reg[i+1];
            end
            pl_reg[FRAME_LEN-1] <= rx_byte;
        end
    end

    assign ev.command     = pl_reg[0];
    assign ev.param_one   = {pl_reg[4], pl_reg[3], pl_reg[2], pl_reg[1]};
    assign ev.param_two   = {pl_reg[8], pl_reg[7], pl_reg[6], pl_reg[5]};
    assign ev.param_three = {pl_reg[12], pl_reg[11], pl_reg[10], pl_reg[9]};

endmodule

>>> sv/flef_out_stage.sv
// Result register that holds one event until the receiver takes it.
module flef_out_stage
    import flef_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  logic   ev_valid,
    input  event_t ev,
    input  logic   out_ready,
    output logic   out_valid,
    output event_t out_event
);

    logic   valid_reg;
    event_t event_reg;

    assign out_valid = valid_reg;
    assign out_event = event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= ev_valid;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ev_valid)
        begin
            event_reg <= ev;
        end
    end

endmodule

>>> sv/fixed_length_event_frame_parser_top.sv
// Top level of the fixed-length event frame parser.
//
// The rx channel carries one received byte per item. The parser hunts for the
// header byte (configuration register 0), expects a length byte of 13, collects
// 13 payload bytes and skips two trailer bytes. After the second trailer byte it
// delivers one item on the evt channel, holding the command byte and three signed
// little-endian 32-bit parameters, provided event delivery (register 1) is on.
//
// Throughput is one byte per cycle while the receiver does not stall. A byte is
// accepted into the input register and parsed from there; an event is loaded
// into the result register when its last trailer byte is parsed and is offered
// on evt from it. These two registers bound the single stage of parsing logic.
//
// When the receiver stalls with an event waiting, the result register keeps that
// event and the input register can still take one byte; every further byte is
// held off until the event has been taken, whether or not it would make one.
// Reset returns the parser to hunting, empties both registers and restores the
// header value 0x55 with event delivery on. The user must write configuration
// via cfg_we, cfg_index and cfg_data while the block is idle; it does not check.
module fixed_length_event_frame_parser_top
    import flef_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    flef_byte_if.sink        rx,
    flef_event_if.source     evt,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [7:0] header_value_reg;
    logic       event_enable_reg;

    logic       hold_valid;
    logic [7:0] hold_byte;
    logic       advance;
    logic       ev_valid;
    event_t     ev;
    event_t     out_event;

    // Configuration registers; there is no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg <= 8'h55;
            event_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_VALUE: header_value_reg <= cfg_data[7:0];
                CFG_EVENT_ENABLE: event_enable_reg <= cfg_data[0];
                default:          header_value_reg <= header_value_reg;
            endcase
        end
    end

    // The held byte is parsed whenever the result register is free or is being
    // emptied in the same cycle; a byte that yields no event still waits so that
    // the order of events is kept simple and a stall never loses a result.
    assign advance = hold_valid && (!evt.valid || evt.ready);

    flef_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_byte    (rx.rx_byte),
        .advance    (advance),
        .in_ready   (rx.ready),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    flef_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .rx_byte      (hold_byte),
        .header_value (header_value_reg),
        .event_enable (event_enable_reg),
        .ev_valid     (ev_valid),
        .ev           (ev)
    );

    flef_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .ev_valid  (ev_valid),
        .ev        (ev),
        .out_ready (evt.ready),
        .out_valid (evt.valid),
        .out_event (out_event)
    );

    assign evt.command     = out_event.command;
    assign evt.param_one   = out_event.param_one;
    assign evt.param_two   = out_event.param_two;
    assign evt.param_three = out_event.param_three;

    // A new event only ever comes from a parsed second trailer byte.
    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt.valid) |-> $past(advance && ev_valid))
        else $error("event appeared without a completed frame");

    // With delivery switched off the parser never offers an event.
    a_event_gated: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> event_enable_reg)
        else $error("event offered while delivery is off");

    // A held byte that cannot move on blocks the input channel.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid && !advance) |-> !rx.ready)
        else $error("input register would be overwritten");

endmodule
